/* rtl/core/lpr_pkg.sv */
// Shared types and constants for the line pixel rasterizer.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package lpr_pkg;

    // Frame size register width and reset values
    localparam int FRAME_W = 15;
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 15'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 15'd480;

    // Configuration port widths; register i sits at byte address 4*i
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index as taken from paddr bit 2
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Input item codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Frame size as seen by the clipping logic
    typedef struct packed {
        logic [FRAME_W-1:0] width;
        logic [FRAME_W-1:0] height;
    } frame_cfg_t;

    // Command kind carried through the queue
    typedef enum logic {
        CMD_LOAD,
        CMD_TICK
    } cmd_kind_t;

    // Back end sequencer states
    typedef enum logic {
        BK_RUN,
        BK_WAIT_DIV
    } back_state_t;

    // Divider sequencer states
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_STEP,
        DV_DONE
    } div_state_t;

endpackage

`default_nettype wire

/* rtl/core/lpr_regs.sv */
// Frame size registers behind an APB-style write/read port.
// Depends on lpr_pkg for widths, reset values and register indexes.
`default_nettype none

module lpr_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output lpr_pkg::frame_cfg_t                    frame_cfg
);

    logic [lpr_pkg::FRAME_W-1:0] width_reg;
    logic [lpr_pkg::FRAME_W-1:0] height_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lpr_pkg::FRAME_WIDTH_RESET;
            height_reg <= lpr_pkg::FRAME_HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                lpr_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[lpr_pkg::FRAME_W-1:0];
                lpr_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[lpr_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (paddr[2])
            lpr_pkg::REG_FRAME_WIDTH:
                prdata = {{(lpr_pkg::APB_DATA_W-lpr_pkg::FRAME_W){1'b0}}, width_reg};
            lpr_pkg::REG_FRAME_HEIGHT:
                prdata = {{(lpr_pkg::APB_DATA_W-lpr_pkg::FRAME_W){1'b0}}, height_reg};
            default:
                prdata = '0;
        endcase
    end

    assign frame_cfg.width  = width_reg;
    assign frame_cfg.height = height_reg;

endmodule

`default_nettype wire

/* rtl/core/lpr_front.sv */
// Front end: accepts input items, classifies them as load or tick,
// precomputes line deltas and holds them in a two-entry queue. Uses lpr_pkg.
`default_nettype none

module lpr_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic signed [COORD_WIDTH-1:0] s_x_start,
    input  wire logic signed [COORD_WIDTH-1:0] s_y_start,
    input  wire logic signed [COORD_WIDTH-1:0] s_x_end,
    input  wire logic signed [COORD_WIDTH-1:0] s_y_end,
    input  wire logic        [7:0]             s_red_in,
    input  wire logic        [7:0]             s_green_in,
    input  wire logic        [7:0]             s_blue_in,
    // queue head toward the back end
    output logic                               q_valid,
    input  wire logic                          q_pop,
    output lpr_pkg::cmd_kind_t                 q_kind,
    output logic             [COORD_WIDTH-1:0] q_ox,
    output logic             [COORD_WIDTH-1:0] q_oy,
    output logic             [COORD_WIDTH-1:0] q_dx,
    output logic                               q_line_ok,
    output logic             [COORD_WIDTH-1:0] q_dy_mag,
    output logic                               q_dy_neg,
    output logic             [23:0]            q_color
);

    localparam int CW     = COORD_WIDTH;
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        lpr_pkg::cmd_kind_t kind;
        logic [CW-1:0]      ox;
        logic [CW-1:0]      oy;
        logic [CW-1:0]      dx;
        logic               line_ok;
        logic [CW-1:0]      dy_mag;
        logic               dy_neg;
        logic [23:0]        color;
    } entry_t;

    entry_t           queue_reg [QDepth];
    entry_t           entry_new;
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;
    logic [QCntW-1:0] count_next;
    logic             push;
    logic [CW:0]      dx_full;
    logic [CW:0]      dy_full;
    logic [CW:0]      dy_abs;

    assign s_ready = (count_reg != QCntW'(QDepth));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);

    // Classify the item and work out the deltas at full width
    always_comb begin
        dx_full = {s_x_end[CW-1], s_x_end} - {s_x_start[CW-1], s_x_start};
        dy_full = {s_y_end[CW-1], s_y_end} - {s_y_start[CW-1], s_y_start};
        dy_abs  = dy_full[CW] ? (~dy_full + 1'b1) : dy_full;

        entry_new.kind    = (s_mode == lpr_pkg::MODE_LOAD) ? lpr_pkg::CMD_LOAD
                                                           : lpr_pkg::CMD_TICK;
        entry_new.ox      = s_x_start;
        entry_new.oy      = s_y_start;
        entry_new.dx      = dx_full[CW-1:0];
        entry_new.line_ok = !dx_full[CW];
        entry_new.dy_mag  = dy_abs[CW-1:0];
        entry_new.dy_neg  = dy_full[CW];
        entry_new.color   = {s_red_in, s_green_in, s_blue_in};
    end

    // Store an accepted item
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry_new;
        end
    end

    // Advance pointers and fill count
    always_comb begin
        count_next = count_reg;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Present the queue head
    assign q_kind    = queue_reg[rd_ptr_reg].kind;
    assign q_ox      = queue_reg[rd_ptr_reg].ox;
    assign q_oy      = queue_reg[rd_ptr_reg].oy;
    assign q_dx      = queue_reg[rd_ptr_reg].dx;
    assign q_line_ok = queue_reg[rd_ptr_reg].line_ok;
    assign q_dy_mag  = queue_reg[rd_ptr_reg].dy_mag;
    assign q_dy_neg  = queue_reg[rd_ptr_reg].dy_neg;
    assign q_color   = queue_reg[rd_ptr_reg].color;

endmodule

`default_nettype wire

/* rtl/core/lpr_divider.sv */
// Row target unit: multiplies |dy| by the column offset, then divides by dx
// with a restoring divider, one quotient bit per cycle. Uses lpr_pkg.
`default_nettype none

module lpr_divider #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [COORD_WIDTH-1:0] factor_a,
    input  wire logic [COORD_WIDTH-1:0] factor_b,
    input  wire logic [COORD_WIDTH-1:0] divisor,
    output logic                        done,
    output logic      [COORD_WIDTH-1:0] quotient
);

    localparam int CW   = COORD_WIDTH;
    localparam int CntW = $clog2(CW);

    lpr_pkg::div_state_t state_reg;
    lpr_pkg::div_state_t state_next;

    logic [CW-1:0]   a_reg;
    logic [CW-1:0]   b_reg;
    logic [CW-1:0]   d_reg;
    logic [CW-1:0]   rem_reg;
    logic [CW-1:0]   lo_reg;
    logic [CntW-1:0] cnt_reg;
    logic [2*CW-1:0] product;
    logic [CW:0]     trial;
    logic [CW+1:0]   diff;
    logic            take;

    assign product = a_reg * b_reg;

    // One restoring step; the remainder stays below the divisor
    assign trial = {rem_reg, lo_reg[CW-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};
    assign take  = !diff[CW+1];

    // Sequence multiply, steps and done
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpr_pkg::DV_IDLE: if (start) state_next = lpr_pkg::DV_MUL;
            lpr_pkg::DV_MUL:  state_next = lpr_pkg::DV_STEP;
            lpr_pkg::DV_STEP: if (cnt_reg == '0) state_next = lpr_pkg::DV_DONE;
            lpr_pkg::DV_DONE: state_next = lpr_pkg::DV_IDLE;
            default:          state_next = lpr_pkg::DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpr_pkg::DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Operand, product and remainder datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            lpr_pkg::DV_IDLE: begin
                if (start) begin
                    a_reg <= factor_a;
                    b_reg <= factor_b;
                    d_reg <= divisor;
                end
            end
            lpr_pkg::DV_MUL: begin
                rem_reg <= product[2*CW-1:CW];
                lo_reg  <= product[CW-1:0];
                cnt_reg <= CntW'(CW - 1);
            end
            lpr_pkg::DV_STEP: begin
                rem_reg <= take ? diff[CW-1:0] : trial[CW-1:0];
                lo_reg  <= {lo_reg[CW-2:0], take};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    assign done     = (state_reg == lpr_pkg::DV_DONE);
    assign quotient = lo_reg;

endmodule

`default_nettype wire

/* rtl/core/lpr_back.sv */
// Back end: executes load and tick commands, steps the line position,
// clips pixels and holds the result register. Uses lpr_pkg and lpr_divider.
`default_nettype none

module lpr_back #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lpr_pkg::frame_cfg_t           frame_cfg,
    // queue head
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire lpr_pkg::cmd_kind_t            q_kind,
    input  wire logic        [COORD_WIDTH-1:0] q_ox,
    input  wire logic        [COORD_WIDTH-1:0] q_oy,
    input  wire logic        [COORD_WIDTH-1:0] q_dx,
    input  wire logic                          q_line_ok,
    input  wire logic        [COORD_WIDTH-1:0] q_dy_mag,
    input  wire logic                          q_dy_neg,
    input  wire logic        [23:0]            q_color,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed      [COORD_WIDTH:0]   m_pixel_x,
    output logic signed      [COORD_WIDTH:0]   m_pixel_y,
    output logic             [7:0]             m_red,
    output logic             [7:0]             m_green,
    output logic             [7:0]             m_blue,
    output logic                               m_write_enable,
    output logic                               m_last
);

    localparam int CW   = COORD_WIDTH;
    localparam int CmpW = ((CW > lpr_pkg::FRAME_W) ? CW : lpr_pkg::FRAME_W) + 1;

    lpr_pkg::back_state_t state_reg;
    lpr_pkg::back_state_t state_next;

    // line state
    logic [CW-1:0] ox_reg;
    logic [CW-1:0] oy_reg;
    logic [CW-1:0] dx_reg;
    logic [CW-1:0] dy_mag_reg;
    logic          dy_neg_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] target_reg;
    logic [23:0]   color_reg;
    logic          drawing_reg;

    // result register
    logic          m_valid_reg;
    logic [CW:0]   px_reg;
    logic [CW:0]   py_reg;
    logic [23:0]   rgb_reg;
    logic          we_reg;
    logic          last_reg;

    logic          out_free;
    logic          do_load;
    logic          do_emit;
    logic          row_step;
    logic          line_end;
    logic          div_start;
    logic          div_done;
    logic [CW-1:0] div_quot;
    logic [CW-1:0] col_inc;
    logic [CW:0]   px;
    logic [CW:0]   py;
    logic [CW:0]   row_ext;
    logic          in_frame;

    assign out_free = !m_valid_reg || m_ready;

    // Pixel position and clipping for the current step
    always_comb begin
        row_ext  = {1'b0, row_reg};
        px       = {ox_reg[CW-1], ox_reg} + {1'b0, col_reg};
        py       = {oy_reg[CW-1], oy_reg} + (dy_neg_reg ? (~row_ext + 1'b1) : row_ext);
        in_frame = !px[CW] && !py[CW]
                && ({{(CmpW-CW){1'b0}}, px[CW-1:0]}
                    < {{(CmpW-lpr_pkg::FRAME_W){1'b0}}, frame_cfg.width})
                && ({{(CmpW-CW){1'b0}}, py[CW-1:0]}
                    < {{(CmpW-lpr_pkg::FRAME_W){1'b0}}, frame_cfg.height});
    end

    assign row_step = (row_reg < target_reg);
    assign line_end = (col_reg == dx_reg);
    assign col_inc  = col_reg + 1'b1;

    // Decide what the head command does this cycle
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        do_load    = 1'b0;
        do_emit    = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            lpr_pkg::BK_RUN: begin
                if (q_valid) begin
                    if (q_kind == lpr_pkg::CMD_LOAD) begin
                        q_pop   = 1'b1;
                        do_load = 1'b1;
                    end else if (!drawing_reg) begin
                        // drop a tick with no line pending
                        q_pop = 1'b1;
                    end else if (out_free) begin
                        q_pop   = 1'b1;
                        do_emit = 1'b1;
                        if (!row_step && !line_end) begin
                            div_start  = 1'b1;
                            state_next = lpr_pkg::BK_WAIT_DIV;
                        end
                    end
                end
            end
            lpr_pkg::BK_WAIT_DIV: begin
                if (div_done) begin
                    state_next = lpr_pkg::BK_RUN;
                end
            end
            default: state_next = lpr_pkg::BK_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpr_pkg::BK_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // Drawing flag and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drawing_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (do_load) begin
                drawing_reg <= q_line_ok;
            end else if (do_emit && !row_step && line_end) begin
                drawing_reg <= 1'b0;
            end
            if (do_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Latch a new line or advance the current one
    always_ff @(posedge aclk) begin
        if (do_load) begin
            ox_reg     <= q_ox;
            oy_reg     <= q_oy;
            dx_reg     <= q_dx;
            dy_mag_reg <= q_dy_mag;
            dy_neg_reg <= q_dy_neg;
            color_reg  <= q_color;
            col_reg    <= '0;
            row_reg    <= '0;
            target_reg <= (q_dx == '0) ? q_dy_mag : '0;
        end else if (do_emit) begin
            if (row_step) begin
                row_reg <= row_reg + 1'b1;
            end else if (!line_end) begin
                col_reg <= col_inc;
            end
        end else if (state_reg == lpr_pkg::BK_WAIT_DIV && div_done) begin
            target_reg <= div_quot;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (do_emit) begin
            px_reg   <= px;
            py_reg   <= py;
            rgb_reg  <= color_reg;
            we_reg   <= in_frame;
            last_reg <= !row_step && line_end;
        end
    end

    lpr_divider #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .factor_a (dy_mag_reg),
        .factor_b (col_inc),
        .divisor  (dx_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = px_reg;
    assign m_pixel_y      = py_reg;
    assign m_red          = rgb_reg[23:16];
    assign m_green        = rgb_reg[15:8];
    assign m_blue         = rgb_reg[7:0];
    assign m_write_enable = we_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

/* rtl/core/line_pixel_rasterizer_top.sv */
// Line pixel rasterizer top level: input channel, result channel, frame registers.
// Instantiates lpr_regs, lpr_front and lpr_back; uses lpr_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready): s_mode 0 loads a line from (x_start, y_start)
//   to (x_end, y_end) with a colour and gives no result; s_mode 1 is a tick that
//   yields the next pixel of the line, or nothing when no line is pending.
//   Result channel (m_valid/m_ready): pixel position, colour, write_enable set when
//   the pixel lies inside the frame, and last on the final pixel of the line.
//   Frame registers: frame_width at address 0, frame_height at address 4; write
//   them only while the block is idle.
//   Flow: an item enters the two-entry command queue; a tick's result is loaded from
//   the queue head into the result register. A tick that moves within a column is
//   done by the back end alone. A tick that moves to a new column then occupies the
//   row target unit for one multiply, one divider step per quotient bit and a hand-off;
//   the back end takes no further command until the unit is done, while the queue
//   still accepts items.
//   Stalls: the result register holds while m_ready is low; up to two further items
//   are queued, then s_ready drops.
//   Reset: frame size returns to 640 x 480, the queue empties and no line is pending.
`default_nettype none

module line_pixel_rasterizer_top #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lpr_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [lpr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [lpr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_mode,
    input  wire logic signed [COORD_WIDTH-1:0]       s_x_start,
    input  wire logic signed [COORD_WIDTH-1:0]       s_y_start,
    input  wire logic signed [COORD_WIDTH-1:0]       s_x_end,
    input  wire logic signed [COORD_WIDTH-1:0]       s_y_end,
    input  wire logic        [7:0]                   s_red_in,
    input  wire logic        [7:0]                   s_green_in,
    input  wire logic        [7:0]                   s_blue_in,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [COORD_WIDTH:0]         m_pixel_x,
    output logic signed      [COORD_WIDTH:0]         m_pixel_y,
    output logic             [7:0]                   m_red,
    output logic             [7:0]                   m_green,
    output logic             [7:0]                   m_blue,
    output logic                                     m_write_enable,
    output logic                                     m_last
);

    lpr_pkg::frame_cfg_t      frame_cfg;
    lpr_pkg::cmd_kind_t       q_kind;
    logic                     q_valid;
    logic                     q_pop;
    logic [COORD_WIDTH-1:0]   q_ox;
    logic [COORD_WIDTH-1:0]   q_oy;
    logic [COORD_WIDTH-1:0]   q_dx;
    logic                     q_line_ok;
    logic [COORD_WIDTH-1:0]   q_dy_mag;
    logic                     q_dy_neg;
    logic [23:0]              q_color;

    // Frame size registers
    lpr_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .frame_cfg (frame_cfg)
    );

    // Accept and queue commands
    lpr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_x_start  (s_x_start),
        .s_y_start  (s_y_start),
        .s_x_end    (s_x_end),
        .s_y_end    (s_y_end),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_kind     (q_kind),
        .q_ox       (q_ox),
        .q_oy       (q_oy),
        .q_dx       (q_dx),
        .q_line_ok  (q_line_ok),
        .q_dy_mag   (q_dy_mag),
        .q_dy_neg   (q_dy_neg),
        .q_color    (q_color)
    );

    // Execute commands and drive results
    lpr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .frame_cfg      (frame_cfg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_kind         (q_kind),
        .q_ox           (q_ox),
        .q_oy           (q_oy),
        .q_dx           (q_dx),
        .q_line_ok      (q_line_ok),
        .q_dy_mag       (q_dy_mag),
        .q_dy_neg       (q_dy_neg),
        .q_color        (q_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_write_enable (m_write_enable),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

/* test/tb_line_pixel_rasterizer_top.sv */
// Self-checking testbench for line_pixel_rasterizer_top: load and tick items in, pixels out,
// with a scoreboard class that predicts every pixel and checks the result channel.
// Depends on lpr_pkg and line_pixel_rasterizer_top.
`timescale 1ns / 1ps

module tb_line_pixel_rasterizer_top;

    localparam int CW            = 16;
    localparam int CLK_HALF      = 4;
    // room for the row target unit to finish two new-column divisions
    localparam int SETTLE_CYCLES = 2 * (CW + 3) + 10;
    localparam int RUN_LIMIT_NS  = 6_000_000;
    localparam int PHASE_ITEMS   = 384;
    localparam logic [lpr_pkg::APB_ADDR_W-1:0] ADDR_WIDTH  = {lpr_pkg::REG_FRAME_WIDTH, 2'b00};
    localparam logic [lpr_pkg::APB_ADDR_W-1:0] ADDR_HEIGHT = {lpr_pkg::REG_FRAME_HEIGHT, 2'b00};

    typedef struct {
        logic                 mode;
        logic signed [CW-1:0] x_start;
        logic signed [CW-1:0] y_start;
        logic signed [CW-1:0] x_end;
        logic signed [CW-1:0] y_end;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
    } line_cmd_t;

    typedef struct {
        logic signed [CW:0] x;
        logic signed [CW:0] y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               write_enable;
        logic               last;
    } pixel_t;

    // Line walker that predicts each pixel and holds the pixels still owed
    class pixel_scoreboard;
        pixel_t                      owed_pixels[$];
        logic [lpr_pkg::FRAME_W-1:0] width_limit  = lpr_pkg::FRAME_WIDTH_RESET;
        logic [lpr_pkg::FRAME_W-1:0] height_limit = lpr_pkg::FRAME_HEIGHT_RESET;
        logic signed [CW-1:0] org_x = '0;
        logic signed [CW-1:0] org_y = '0;
        logic signed [CW:0]   dx = '0;
        logic signed [CW:0]   dy = '0;
        // one spare bit so the column past the end of a full-width line stays positive
        logic signed [CW+1:0] col = '0;
        logic signed [CW+1:0] row = '0;
        logic signed [CW:0]   row_goal = '0;
        logic [7:0]           color_r = '0;
        logic [7:0]           color_g = '0;
        logic [7:0]           color_b = '0;
        bit                   active = 0;
        int                   errors, loads, pixels, clipped, line_ends;

        function void set_frame(logic [lpr_pkg::FRAME_W-1:0] w,
                                logic [lpr_pkg::FRAME_W-1:0] h);
            width_limit  = w;
            height_limit = h;
        endfunction

        // row offset a column must reach: dy*c/dx truncated toward zero, dy when vertical
        function logic signed [CW:0] goal_for(logic signed [CW+1:0] c);
            longint q;
            if (dx == 0)
                q = longint'(dy);
            else
                q = (longint'(dy) * longint'(c)) / longint'(dx);
            return q[CW:0];
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Return 1 when the item changed state or owes a pixel
        function bit note_item(line_cmd_t cmd);
            longint             px, py;
            pixel_t             p;
            logic signed [CW:0] step;
            if (cmd.mode == lpr_pkg::MODE_LOAD) begin
                org_x    = cmd.x_start;
                org_y    = cmd.y_start;
                dx       = cmd.x_end - cmd.x_start;
                dy       = cmd.y_end - cmd.y_start;
                color_r  = cmd.red;
                color_g  = cmd.green;
                color_b  = cmd.blue;
                col      = '0;
                row      = '0;
                active   = !dx[CW];
                row_goal = active ? goal_for('0) : '0;
                loads++;
                return 1;
            end
            if (!active)
                return 0;

            px = longint'(org_x) + longint'(col);
            py = longint'(org_y) + longint'(row);
            p.x     = px[CW:0];
            p.y     = py[CW:0];
            p.red   = color_r;
            p.green = color_g;
            p.blue  = color_b;
            p.write_enable = px >= 0 && px < longint'(width_limit) &&
                             py >= 0 && py < longint'(height_limit);
            p.last  = 1'b0;

            // advance the row within the column, else move to the next column
            step = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
            if (mag(longint'(row)) < mag(longint'(row_goal))) begin
                row = row + step;
            end else begin
                col = col + 1;
                if (col > dx) begin
                    p.last = 1'b1;
                    active = 0;
                end else begin
                    row_goal = goal_for(col);
                end
            end
            owed_pixels.push_back(p);
            return 1;
        endfunction

        function void report(string name, logic signed [31:0] want, logic signed [31:0] got);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (owed_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d", $time, got.x, got.y);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            if (got.x !== want.x)                       report("pixel_x", want.x, got.x);
            if (got.y !== want.y)                       report("pixel_y", want.y, got.y);
            if (got.red !== want.red)                   report("red", want.red, got.red);
            if (got.green !== want.green)               report("green", want.green, got.green);
            if (got.blue !== want.blue)                 report("blue", want.blue, got.blue);
            if (got.write_enable !== want.write_enable)
                report("write_enable", want.write_enable, got.write_enable);
            if (got.last !== want.last)                 report("last", want.last, got.last);
            pixels++;
            if (!want.write_enable)
                clipped++;
            if (want.last)
                line_ends++;
        endfunction
    endclass

    logic                              aclk    = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [lpr_pkg::APB_ADDR_W-1:0]    paddr   = '0;
    logic [lpr_pkg::APB_DATA_W-1:0]    pwdata  = '0;
    logic [lpr_pkg::APB_DATA_W-1:0]    prdata;
    logic                   pready;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_mode  = 1'b0;
    logic signed [CW-1:0]   s_x_start = '0;
    logic signed [CW-1:0]   s_y_start = '0;
    logic signed [CW-1:0]   s_x_end   = '0;
    logic signed [CW-1:0]   s_y_end   = '0;
    logic [7:0]             s_red_in   = '0;
    logic [7:0]             s_green_in = '0;
    logic [7:0]             s_blue_in  = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [CW:0]     m_pixel_x;
    logic signed [CW:0]     m_pixel_y;
    logic [7:0]             m_red;
    logic [7:0]             m_green;
    logic [7:0]             m_blue;
    logic                   m_write_enable;
    logic                   m_last;

    int tx_idle_pct;
    int rx_idle_pct;
    int effective_items;
    pixel_scoreboard sb;

    line_pixel_rasterizer_top #(
        .COORD_WIDTH(CW)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_x_start      (s_x_start),
        .s_y_start      (s_y_start),
        .s_x_end        (s_x_end),
        .s_y_end        (s_y_end),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_write_enable (m_write_enable),
        .m_last         (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    // Take pixels with random stalls and check each one
    always @(posedge aclk) begin
        pixel_t got;
        if (aresetn && m_valid && m_ready) begin
            got.x            = m_pixel_x;
            got.y            = m_pixel_y;
            got.red          = m_red;
            got.green        = m_green;
            got.blue         = m_blue;
            got.write_enable = m_write_enable;
            got.last         = m_last;
            sb.check_pixel(got);
        end
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Write one frame register, then read it back
    task automatic apb_write(input logic [lpr_pkg::APB_ADDR_W-1:0] addr,
                             input logic [lpr_pkg::FRAME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= (lpr_pkg::APB_DATA_W)'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[lpr_pkg::FRAME_W-1:0] !== value) begin
            $display("%0t: register %0d read mismatch: expected %0d, actual %0d",
                     $time, addr, value, prdata[lpr_pkg::FRAME_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input logic [lpr_pkg::FRAME_W-1:0] w,
                             input logic [lpr_pkg::FRAME_W-1:0] h);
        apb_write(ADDR_WIDTH, w);
        apb_write(ADDR_HEIGHT, h);
        sb.set_frame(w, h);
    endtask

    // Present one item and hold it until accepted
    task automatic send_item(input line_cmd_t cmd);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= cmd.mode;
        s_x_start  <= cmd.x_start;
        s_y_start  <= cmd.y_start;
        s_x_end    <= cmd.x_end;
        s_y_end    <= cmd.y_end;
        s_red_in   <= cmd.red;
        s_green_in <= cmd.green;
        s_blue_in  <= cmd.blue;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (sb.note_item(cmd))
            effective_items++;
    endtask

    // Drop valid, wait for every owed pixel, then let the row target unit settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic line_cmd_t random_cmd(input logic mode);
        line_cmd_t cmd;
        cmd.mode    = mode;
        cmd.x_start = CW'($urandom);
        cmd.y_start = CW'($urandom);
        cmd.x_end   = CW'($urandom);
        cmd.y_end   = CW'($urandom);
        cmd.red     = 8'($urandom);
        cmd.green   = 8'($urandom);
        cmd.blue    = 8'($urandom);
        return cmd;
    endfunction

    task automatic load_line(input int xs, input int ys, input int xe, input int ye,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        line_cmd_t cmd;
        cmd.mode    = lpr_pkg::MODE_LOAD;
        cmd.x_start = CW'(xs);
        cmd.y_start = CW'(ys);
        cmd.x_end   = CW'(xe);
        cmd.y_end   = CW'(ye);
        cmd.red     = r;
        cmd.green   = g;
        cmd.blue    = b;
        send_item(cmd);
    endtask

    task automatic tick_n(input int n);
        repeat (n) send_item(random_cmd(lpr_pkg::MODE_TICK));
    endtask

    // Load a short line near or far from the frame, then tick part, all or past the end of it
    task automatic draw_random_line();
        line_cmd_t cmd;
        int        x0, y0, span_x, span_y, len, ticks;
        cmd = random_cmd(lpr_pkg::MODE_LOAD);
        if ($urandom_range(0, 1)) begin
            x0 = int'($urandom_range(0, int'(sb.width_limit) + 8)) - 4;
            y0 = int'($urandom_range(0, int'(sb.height_limit) + 8)) - 4;
            if (x0 > 32767) x0 = 32767;
            if (y0 > 32767) y0 = 32767;
            cmd.x_start = CW'(x0);
            cmd.y_start = CW'(y0);
        end
        case ($urandom_range(0, 19))
            0, 1:    span_x = -int'($urandom_range(1, 6));
            2:       span_x = $urandom_range(13, 40);
            default: span_x = $urandom_range(0, 12);
        endcase
        if ($urandom_range(0, 9) == 0)
            span_y = int'($urandom_range(13, 40));
        else
            span_y = int'($urandom_range(0, 12));
        if ($urandom_range(0, 1))
            span_y = -span_y;
        cmd.x_end = CW'(int'(cmd.x_start) + span_x);
        cmd.y_end = CW'(int'(cmd.y_start) + span_y);
        send_item(cmd);

        if (span_x < 0) begin
            ticks = $urandom_range(1, 2);
        end else begin
            len   = span_x + (span_y < 0 ? -span_y : span_y) + 1;
            ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len)
                                                : len + $urandom_range(0, 2);
        end
        tick_n(ticks);

        // now and then hold off until the block has caught up
        if ($urandom_range(0, 24) == 0)
            drain();
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
        int stop_at;
        stop_at     = effective_items + items;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (effective_items < stop_at) begin
            if ($urandom_range(0, 99) < 8)
                send_item(random_cmd(1'($urandom_range(0, 1))));
            else
                draw_random_line();
        end
    endtask

    // Main sequence
    initial begin
        sb = new;
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tick with no line pending
        tick_n(1);
        // shallow line, run past its end
        load_line(0, 0, 3, 2, 8'hFF, 8'h00, 8'hAA);
        tick_n(7);
        // reversed line at the coordinate extremes draws nothing
        load_line(32767, 32767, -32768, -32768, 8'h00, 8'hFF, 8'h00);
        tick_n(1);
        // vertical line going up
        load_line(10, 10, 10, 7, 8'h55, 8'hAA, 8'hFF);
        tick_n(4);
        // flat line partly left of the frame, cut short by the next load
        load_line(-2, 5, 2, 5, 8'h80, 8'h01, 8'h7F);
        tick_n(3);
        // full-range diagonal
        load_line(-32768, -32768, 32767, 32767, 8'h00, 8'h00, 8'h00);
        tick_n(3);
        drain();

        // zero-size frame clips everything
        set_frame(0, 0);
        load_line(0, 0, 1, 1, 8'hFF, 8'hFF, 8'hFF);
        tick_n(3);
        drain();

        set_frame(32767, 1);
        run_phase(37, 85, PHASE_ITEMS);
        drain();
        set_frame(1, 32767);
        run_phase(85, 37, PHASE_ITEMS);
        drain();
        set_frame($urandom_range(2, 400), $urandom_range(2, 300));
        run_phase(0, 0, PHASE_ITEMS);
        drain();

        $display("Run covered %0d loads and %0d checked pixels (%0d clipped, %0d line ends),",
                 sb.loads, sb.pixels, sb.clipped, sb.line_ends);
        $display("over reset, zero, extreme and random frame sizes with mixed stalls.");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
